// File: hdl/ipv6rf_pkg.sv
// ipv6rf_pkg: types and constants shared by the receive filter and its group cells
// no dependencies; compile first

package ipv6rf_pkg;

   // action codes of a request
   localparam logic [1:0] ACT_RECEIVE = 2'd0;
   localparam logic [1:0] ACT_JOIN    = 2'd1;
   localparam logic [1:0] ACT_LEAVE   = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_DROPPED    = 3'd1;
   localparam logic [2:0] STAT_NOT_MCAST  = 3'd2;
   localparam logic [2:0] STAT_NO_SPACE   = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND  = 3'd4;

   // register indexes on the csr port
   localparam logic [2:0] REG_ENABLE        = 3'd0;
   localparam logic [2:0] REG_LINK_LOCAL_HI = 3'd1;
   localparam logic [2:0] REG_LINK_LOCAL_LO = 3'd2;
   localparam logic [2:0] REG_GLOBAL_HI     = 3'd3;
   localparam logic [2:0] REG_GLOBAL_LO     = 3'd4;
   localparam logic [2:0] REG_SLOT_HEADERS  = 3'd5;
   localparam logic [2:0] REG_SLOT_VALID    = 3'd6;

   // header constants
   localparam logic [15:0] HDR_BYTES    = 16'd40;
   localparam logic [3:0]  IP_VERSION   = 4'd6;
   localparam logic [7:0]  MCAST_PREFIX = 8'hFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  version;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  next_hdr;
      logic [15:0] ip_plen;
      logic [15:0] frame_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  handler_mask;
      logic [15:0] data_len;
   } rsp_type;

   // command broadcast from the controller to every group cell
   typedef struct packed {
      logic        capture;
      logic        commit;
      logic        join_new;
      logic        leave;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } cell_cmd_type;

   // priority flags passed from cell to cell
   typedef struct packed {
      logic match_any;
      logic free_any;
   } chain_type;

   // table updates made by one cell
   typedef struct packed {
      logic set;
      logic clr;
   } cell_wr_type;

endpackage

// File: hdl/ipv6rf_cell.sv
// ipv6rf_cell: one multicast group entry with its compare and priority link
// depends on ipv6rf_pkg

module ipv6rf_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  ipv6rf_pkg::cell_cmd_type cmd,
   input  ipv6rf_pkg::chain_type    chain_in,
   output ipv6rf_pkg::chain_type    chain_out,
   output ipv6rf_pkg::cell_wr_type  wr
);

   logic        used_ff, used_in;
   logic        match_ff, match_in;
   logic [63:0] addr_hi_ff, addr_hi_in;
   logic [63:0] addr_lo_ff, addr_lo_in;

   // compare against the request address, held through the resolve state
   assign match_in = cmd.capture ? (used_ff && addr_hi_ff == cmd.addr_hi &&
                                    addr_lo_ff == cmd.addr_lo)
                                 : match_ff;

   // first free cell takes a new group, first matching cell is freed on leave
   assign wr.set = cmd.commit && cmd.join_new && !used_ff && !chain_in.free_any;
   assign wr.clr = cmd.commit && cmd.leave && match_ff && !chain_in.match_any;

   assign used_in    = wr.set ? 1'b1 : (wr.clr ? 1'b0 : used_ff);
   assign addr_hi_in = wr.set ? cmd.addr_hi : addr_hi_ff;
   assign addr_lo_in = wr.set ? cmd.addr_lo : addr_lo_ff;

   // pass priority flags to the next cell
   assign chain_out.match_any = chain_in.match_any || match_ff;
   assign chain_out.free_any  = chain_in.free_any || !used_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         match_ff <= match_in;
      end
   end

   // group address storage
   always_ff @(posedge clock) begin
      addr_hi_ff <= addr_hi_in;
      addr_lo_ff <= addr_lo_in;
   end

endmodule

// File: hdl/ipv6_receive_filter_group_table_unit.sv
// ipv6_receive_filter_group_table_unit: ipv6 receive filter with a multicast group table
// an accepted request passes the match and resolve states and retires into the output
// register, and the next is taken only as it retires; the group cells compare in the match
// state and resolve first-match / first-free priority along the row in the resolve state
// reset: synchronous, clears state, config registers, group used bits and the output valid
// depends on ipv6rf_pkg and ipv6rf_cell

module ipv6_receive_filter_group_table_unit #(
   parameter int GROUP_ENTRIES = 8,
   parameter int SLOTS         = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ipv6rf_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ipv6rf_pkg::rsp_type rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [5:0]          csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_MATCH   = 3'b010,
      ST_RESOLVE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic        enable_ff, enable_in;
   logic [63:0] link_local_hi_ff, link_local_hi_in;
   logic [63:0] link_local_lo_ff, link_local_lo_in;
   logic [63:0] global_hi_ff, global_hi_in;
   logic [63:0] global_lo_ff, global_lo_in;
   logic [63:0] slot_headers_ff, slot_headers_in;
   logic [7:0]  slot_valid_ff, slot_valid_in;

   ipv6rf_pkg::req_type item_ff, item_in;
   ipv6rf_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                     csr_write;
   logic [2:0]               csr_index;
   logic                     req_accept;
   logic                     out_free;
   logic                     commit;
   logic                     group_found;
   logic                     group_free;
   logic                     is_mcast;
   logic                     recv_ok;
   logic                     to_ll;
   logic                     to_global;
   logic [15:0]              room;
   logic [7:0]               mask;
   ipv6rf_pkg::rsp_type      result;
   ipv6rf_pkg::cell_cmd_type cmd;
   ipv6rf_pkg::chain_type    link [GROUP_ENTRIES+1];
   logic [GROUP_ENTRIES-1:0] set_vec;
   logic [GROUP_ENTRIES-1:0] clr_vec;

   // csr write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[5:3];

   always_comb begin
      enable_in        = enable_ff;
      link_local_hi_in = link_local_hi_ff;
      link_local_lo_in = link_local_lo_ff;
      global_hi_in     = global_hi_ff;
      global_lo_in     = global_lo_ff;
      slot_headers_in  = slot_headers_ff;
      slot_valid_in    = slot_valid_ff;
      if (csr_write) begin
         case (csr_index)
            ipv6rf_pkg::REG_ENABLE:        enable_in        = csr_pwdata[0];
            ipv6rf_pkg::REG_LINK_LOCAL_HI: link_local_hi_in = csr_pwdata;
            ipv6rf_pkg::REG_LINK_LOCAL_LO: link_local_lo_in = csr_pwdata;
            ipv6rf_pkg::REG_GLOBAL_HI:     global_hi_in     = csr_pwdata;
            ipv6rf_pkg::REG_GLOBAL_LO:     global_lo_in     = csr_pwdata;
            ipv6rf_pkg::REG_SLOT_HEADERS:  slot_headers_in  = csr_pwdata;
            ipv6rf_pkg::REG_SLOT_VALID:    slot_valid_in    = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ipv6rf_pkg::REG_ENABLE:        csr_prdata = {63'd0, enable_ff};
         ipv6rf_pkg::REG_LINK_LOCAL_HI: csr_prdata = link_local_hi_ff;
         ipv6rf_pkg::REG_LINK_LOCAL_LO: csr_prdata = link_local_lo_ff;
         ipv6rf_pkg::REG_GLOBAL_HI:     csr_prdata = global_hi_ff;
         ipv6rf_pkg::REG_GLOBAL_LO:     csr_prdata = global_lo_ff;
         ipv6rf_pkg::REG_SLOT_HEADERS:  csr_prdata = slot_headers_ff;
         ipv6rf_pkg::REG_SLOT_VALID:    csr_prdata = {56'd0, slot_valid_ff};
         default:                       csr_prdata = 64'd0;
      endcase
   end

   // handshake: take a request when idle or while the current one retires
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == ST_RESOLVE) && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) || commit);
   assign req_accept = req_valid && !req_stall;
   assign item_in    = req_accept ? req_data : item_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:    state_in = req_accept ? ST_MATCH : ST_IDLE;
         ST_MATCH:   state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = commit ? (req_accept ? ST_MATCH : ST_IDLE) : ST_RESOLVE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // command to the group cells
   assign is_mcast     = item_ff.addr_hi[63:56] == ipv6rf_pkg::MCAST_PREFIX;
   assign cmd.capture  = state_ff == ST_MATCH;
   assign cmd.commit   = commit;
   assign cmd.join_new = (item_ff.action == ipv6rf_pkg::ACT_JOIN) && is_mcast && !group_found;
   assign cmd.leave    = item_ff.action == ipv6rf_pkg::ACT_LEAVE;
   assign cmd.addr_hi  = item_ff.addr_hi;
   assign cmd.addr_lo  = item_ff.addr_lo;

   // row of group cells
   assign link[0] = '0;

   for (genvar g = 0; g < GROUP_ENTRIES; g++) begin : g_cell
      ipv6rf_pkg::cell_wr_type wr;

      ipv6rf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (link[g]),
         .chain_out (link[g+1]),
         .wr        (wr)
      );

      assign set_vec[g] = wr.set;
      assign clr_vec[g] = wr.clr;
   end

   assign group_found = link[GROUP_ENTRIES].match_any;
   assign group_free  = link[GROUP_ENTRIES].free_any;

   // receive checks
   assign recv_ok = enable_ff && (item_ff.frame_len >= ipv6rf_pkg::HDR_BYTES) &&
                    (item_ff.version == ipv6rf_pkg::IP_VERSION);
   assign to_ll   = (item_ff.addr_hi == link_local_hi_ff) &&
                    (item_ff.addr_lo == link_local_lo_ff);
   assign to_global = ((global_hi_ff != 64'd0) || (global_lo_ff != 64'd0)) &&
                      (item_ff.addr_hi == global_hi_ff) && (item_ff.addr_lo == global_lo_ff);
   assign room    = item_ff.frame_len - ipv6rf_pkg::HDR_BYTES;

   // dispatch slots matching the next header
   always_comb begin
      mask = 8'd0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid_ff[i] && (slot_headers_ff[8*i +: 8] == item_ff.next_hdr)) begin
            mask[i] = 1'b1;
         end
      end
   end

   // result of the request
   always_comb begin
      result        = '0;
      result.status = ipv6rf_pkg::STAT_DROPPED;
      case (item_ff.action)
         ipv6rf_pkg::ACT_RECEIVE: begin
            if (recv_ok && (to_ll || to_global || is_mcast || group_found)) begin
               result.status       = ipv6rf_pkg::STAT_OK;
               result.handler_mask = mask;
               result.data_len     = (item_ff.ip_plen > room) ? room : item_ff.ip_plen;
            end
         end
         ipv6rf_pkg::ACT_JOIN: begin
            if (!is_mcast) begin
               result.status = ipv6rf_pkg::STAT_NOT_MCAST;
            end else if (group_found || group_free) begin
               result.status = ipv6rf_pkg::STAT_OK;
            end else begin
               result.status = ipv6rf_pkg::STAT_NO_SPACE;
            end
         end
         ipv6rf_pkg::ACT_LEAVE: begin
            result.status = group_found ? ipv6rf_pkg::STAT_OK : ipv6rf_pkg::STAT_NOT_FOUND;
         end
         default: ;
      endcase
   end

   // output register
   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = commit ? result : rsp_data_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         enable_ff        <= 1'b0;
         link_local_hi_ff <= 64'd0;
         link_local_lo_ff <= 64'd0;
         global_hi_ff     <= 64'd0;
         global_lo_ff     <= 64'd0;
         slot_headers_ff  <= 64'd0;
         slot_valid_ff    <= 8'd0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         enable_ff        <= enable_in;
         link_local_hi_ff <= link_local_hi_in;
         link_local_lo_ff <= link_local_lo_in;
         global_hi_ff     <= global_hi_in;
         global_lo_ff     <= global_lo_in;
         slot_headers_ff  <= slot_headers_in;
         slot_valid_ff    <= slot_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // at most one cell takes a new group per request
   assert property (@(posedge clock) disable iff (reset) $onehot0(set_vec))
      else $error("more than one group cell written");

   // at most one cell is freed per request
   assert property (@(posedge clock) disable iff (reset) $onehot0(clr_vec))
      else $error("more than one group cell freed");

   // a retiring request always shows up on the output
   assert property (@(posedge clock) disable iff (reset) commit |=> rsp_valid)
      else $error("retired request produced no response");

   // a table update only happens together with a successful status
   assert property (@(posedge clock) disable iff (reset)
      ((set_vec != '0) || (clr_vec != '0)) |-> (result.status == ipv6rf_pkg::STAT_OK))
      else $error("table changed on a failing request");

endmodule
